// File: rtl/mcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maximum clique search package
// Opcodes, field widths and the command and status words that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package mcs_pkg;

  // Widths of the fields on the ports.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned VERTEX_W = 5;
  localparam int unsigned SIZE_W   = 6;

  // Opcodes carried by an input word.
  localparam logic [OPCODE_W-1:0] OP_CLEAR    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SEARCH   = 2'd2;

  // Value of the vertex count register after reset.
  localparam logic [SIZE_W-1:0] VERTEX_COUNT_RESET = 6'd32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;     // empty the adjacency matrix
    logic add_edge;  // set both directions of one edge
    logic init;      // load the first target size and empty the stack
    logic step;      // one push, pop or target decrement
  } mcs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // the current target size is the answer
  } mcs_status_t;

endpackage

// File: rtl/mcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maximum clique search controller
// Decodes the opcode of an accepted word, drives the datapath through the
// backtracking steps of a search and raises the result strobe.
// ----------------------------------------------------------------------------
module mcs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mcs_pkg::OPCODE_W-1:0]  opcode_i,
  input  mcs_pkg::mcs_status_t          status_i,
  output mcs_pkg::mcs_cmd_t             cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;
  logic   accept;

  assign accept = start_i && !busy_q;

  // Command decode: edits of the graph act on the word at once.
  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = accept && (opcode_i == mcs_pkg::OP_CLEAR);
    cmd_o.add_edge = accept && (opcode_i == mcs_pkg::OP_ADD_EDGE);
    cmd_o.init     = accept && (opcode_i == mcs_pkg::OP_SEARCH);
    cmd_o.step     = (state_q == ST_RUN) && !status_i.done;
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == ST_RUN) && status_i.done;
      unique case (state_q)
        ST_IDLE: begin
          if (accept && (opcode_i == mcs_pkg::OP_SEARCH)) begin
            state_q <= ST_RUN;
            busy_q  <= 1'b1;
          end
        end
        ST_RUN: begin
          if (status_i.done) begin
            state_q <= ST_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: rtl/mcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maximum clique search datapath
// Holds the adjacency matrix, the vertex count, the stack of chosen vertices
// with the candidate mask of each level, and performs one search step a cycle.
// ----------------------------------------------------------------------------
module mcs_datapath #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcs_pkg::mcs_cmd_t             cmd_i,
  input  logic [mcs_pkg::VERTEX_W-1:0]  vertex_u_i,
  input  logic [mcs_pkg::VERTEX_W-1:0]  vertex_v_i,
  input  logic [mcs_pkg::SIZE_W-1:0]    upper_bound_i,
  input  logic                          cfg_we_i,
  input  logic [mcs_pkg::SIZE_W-1:0]    cfg_data_i,
  output mcs_pkg::mcs_status_t          status_o,
  output logic [mcs_pkg::SIZE_W-1:0]    clique_size_o
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  // Graph and configuration.
  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [mcs_pkg::SIZE_W-1:0] vertex_count_q;

  // Search stack: chosen vertex and candidate mask of each level.
  logic [VW-1:0]           chosen_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] cand_q   [MAX_VERTICES];

  logic [CW-1:0] depth_q;
  logic [CW-1:0] target_q;
  logic [CW-1:0] next_q;

  logic [CW-1:0]           n_w;
  logic [CW-1:0]           bound_w;
  logic [VW-1:0]           u_idx;
  logic [VW-1:0]           v_idx;
  logic                    edge_ok;
  logic [MAX_VERTICES-1:0] rd_cand;
  logic [MAX_VERTICES-1:0] avail;
  logic                    has_cand;
  logic [VW-1:0]           pick;
  logic [CW-1:0]           depth_inc;
  logic [CW-1:0]           depth_dec;
  logic                    at_target;
  logic                    is_done;

  // Vertices in use and the clamped first target.
  always_comb begin
    if (int'(vertex_count_q) > int'(MAX_VERTICES)) begin
      n_w = CW'(MAX_VERTICES);
    end else begin
      n_w = CW'(vertex_count_q);
    end
    if (int'(upper_bound_i) > int'(n_w)) begin
      bound_w = n_w;
    end else begin
      bound_w = CW'(upper_bound_i);
    end
  end

  // Edge endpoints; endpoints outside the matrix and self-loops are dropped.
  assign u_idx   = VW'(vertex_u_i);
  assign v_idx   = VW'(vertex_v_i);
  assign edge_ok = (vertex_u_i != vertex_v_i) &&
                   (int'(vertex_u_i) < int'(MAX_VERTICES)) &&
                   (int'(vertex_v_i) < int'(MAX_VERTICES));

  // Candidates at the current level: adjacent to every chosen vertex, not
  // below the resume point, and leaving room for the remaining picks.
  assign rd_cand = cand_q[depth_q[VW-1:0]];

  always_comb begin
    for (int w = 0; w < int'(MAX_VERTICES); w++) begin
      avail[w] = rd_cand[w] && (w >= int'(next_q)) &&
                 (w + int'(target_q) <= int'(n_w) + int'(depth_q));
    end
  end

  assign has_cand = |avail;

  // Lowest candidate wins, matching the ascending order of choice.
  always_comb begin
    pick = '0;
    for (int w = int'(MAX_VERTICES) - 1; w >= 0; w--) begin
      if (avail[w]) begin
        pick = VW'(w);
      end
    end
  end

  assign depth_inc = depth_q + CW'(1);
  assign depth_dec = depth_q - CW'(1);
  assign at_target = (depth_q == target_q);
  assign is_done   = (target_q < CW'(2)) || at_target;

  // Adjacency matrix, configuration and search control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(MAX_VERTICES); r++) begin
        adj_q[r] <= '0;
      end
      vertex_count_q <= mcs_pkg::VERTEX_COUNT_RESET;
      depth_q        <= '0;
      target_q       <= '0;
      next_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        vertex_count_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        for (int r = 0; r < int'(MAX_VERTICES); r++) begin
          adj_q[r] <= '0;
        end
      end else if (cmd_i.add_edge && edge_ok) begin
        adj_q[u_idx][v_idx] <= 1'b1;
        adj_q[v_idx][u_idx] <= 1'b1;
      end
      if (cmd_i.init) begin
        target_q <= bound_w;
        depth_q  <= '0;
        next_q   <= '0;
      end else if (cmd_i.step) begin
        if (has_cand) begin
          depth_q <= depth_inc;
          next_q  <= CW'(pick) + CW'(1);
        end else if (depth_q != '0) begin
          depth_q <= depth_dec;
          next_q  <= CW'(chosen_q[depth_dec[VW-1:0]]) + CW'(1);
        end else begin
          // No clique of this size: try one smaller from scratch.
          target_q <= target_q - CW'(1);
          next_q   <= '0;
        end
      end
    end
  end

  // Stack storage; the bottom mask admits every vertex.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      cand_q[0] <= '1;
    end else if (cmd_i.step && has_cand) begin
      chosen_q[depth_q[VW-1:0]] <= pick;
      if (int'(depth_inc) < int'(MAX_VERTICES)) begin
        cand_q[depth_inc[VW-1:0]] <= rd_cand & adj_q[pick];
      end
    end
  end

  assign status_o.done = is_done;
  assign clique_size_o = mcs_pkg::SIZE_W'(target_q);

endmodule

// File: rtl/max_clique_search_core.sv
`timescale 1ns / 1ps
// Clear and add edge take effect at the accepting edge, give no result and can
// follow one another every cycle while busy is low.
// A search raises done_o for one cycle once the datapath reports done after its
// last push, pop or target-decrement step, the steps running one a cycle;
// busy_o is high until the done_o cycle, in which the next word can be taken.
// The step count grows exponentially with the vertex count in the worst case.
// Reset empties the graph and sets the vertex count to 32; results cannot stall.
// ----------------------------------------------------------------------------
// Maximum clique search core
// Adjacency bit matrix with clear, add edge and maximum clique search.
// ----------------------------------------------------------------------------
module max_clique_search_core #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [mcs_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [mcs_pkg::VERTEX_W-1:0]  vertex_u_i,
  input  logic [mcs_pkg::VERTEX_W-1:0]  vertex_v_i,
  input  logic [mcs_pkg::SIZE_W-1:0]    upper_bound_i,
  output logic                          done_o,
  output logic [mcs_pkg::SIZE_W-1:0]    clique_size_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcs_pkg::SIZE_W-1:0]    cfg_data_i
);

  mcs_pkg::mcs_cmd_t    cmd;
  mcs_pkg::mcs_status_t status;

  // The vertex count register takes a word in any cycle.
  assign cfg_ready_o = 1'b1;

  // Sequencer.
  mcs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Graph storage and search stack.
  mcs_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .vertex_u_i    (vertex_u_i),
    .vertex_v_i    (vertex_v_i),
    .upper_bound_i (upper_bound_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .status_o      (status),
    .clique_size_o (clique_size_o)
  );

endmodule
